// ===== rtl/scu_pkg.sv =====
// scu_pkg: shared constants, filter codes and the beat descriptor for the
// scanline unfilter core. No dependencies.

package scu_pkg;

	localparam int MAX_ROW_BYTES_DEF   = 4096;
	localparam int MAX_PIXEL_BYTES_DEF = 8;

	localparam logic [12:0] ROW_BYTES_RST = 13'd96;
	localparam logic [3:0]  BPP_RST       = 4'd3;

	localparam logic REG_ROW_BYTES = 1'b0;
	localparam logic REG_BPP       = 1'b1;

	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_SUB   = 3'd1;
	localparam logic [2:0] FLT_UP    = 3'd2;
	localparam logic [2:0] FLT_AVG   = 3'd3;
	localparam logic [2:0] FLT_PAETH = 3'd4;

	typedef struct packed {
		logic       is_data;
		logic       first_row;
		logic       has_left;
		logic       last;
		logic [2:0] filt;
		logic [7:0] x;
	} scu_item_t;

	function automatic logic [2:0] filt_decode(input logic [7:0] code);
		if (code > {5'd0, FLT_PAETH}) begin
			filt_decode = FLT_NONE;
		end else begin
			filt_decode = code[2:0];
		end
	endfunction

endpackage

// ===== rtl/scu_line_mem.sv =====
// scu_line_mem: previous-row byte store, one registered read and one write
// per cycle. Depends on nothing.

module scu_line_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [7:0]    wr_data,
	output logic [7:0]    rd_data_s1
);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] addr_s1;

	// write goes to the address of the beat held in stage 1
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			addr_s1    <= rd_addr;
		end
	end

endmodule

// ===== rtl/scu_ctrl.sv =====
// scu_ctrl: row sequencer; tracks byte position, row filter and first-row
// state at input acceptance. Depends on scu_pkg.

module scu_ctrl #(
	parameter int MAX_ROW_BYTES   = scu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = scu_pkg::MAX_PIXEL_BYTES_DEF,
	parameter int AW              = $clog2(MAX_ROW_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        x,
	input  logic              soi,
	input  logic [12:0]       row_bytes,
	input  logic [3:0]        bytes_per_pixel,
	output scu_pkg::scu_item_t item,
	output logic [AW-1:0]     rd_addr,
	output logic [3:0]        bpp_eff
);

	localparam int PW = $clog2(MAX_ROW_BYTES + 2);
	localparam int CW = ((PW > 13) ? PW : 13) + 1;

	logic [PW-1:0] pos_q;
	logic          first_q;
	logic [2:0]    filt_q;

	logic [CW-1:0] len_eff;
	logic [PW-1:0] pos_eff;
	logic          first_eff;
	logic [PW-1:0] idx_w;
	logic [AW-1:0] idx;
	logic          is_data;
	logic          last;
	logic          has_left;

	always_comb begin
		if (row_bytes == 13'd0) begin
			len_eff = CW'(1);
		end else if (CW'(row_bytes) > CW'(MAX_ROW_BYTES)) begin
			len_eff = CW'(MAX_ROW_BYTES);
		end else begin
			len_eff = CW'(row_bytes);
		end
		if (bytes_per_pixel == 4'd0) begin
			bpp_eff = 4'd1;
		end else if (bytes_per_pixel > 4'(MAX_PIXEL_BYTES)) begin
			bpp_eff = 4'(MAX_PIXEL_BYTES);
		end else begin
			bpp_eff = bytes_per_pixel;
		end
	end

	always_comb begin
		pos_eff   = soi ? '0 : pos_q;
		first_eff = soi | first_q;
		is_data   = (pos_eff != '0);
		idx_w     = pos_eff - PW'(1);
		if (idx_w >= PW'(MAX_ROW_BYTES)) begin
			idx_w = PW'(MAX_ROW_BYTES - 1);
		end
		idx      = idx_w[AW-1:0];
		has_left = CW'(idx) >= CW'(bpp_eff);
		last     = (CW'(idx) + CW'(1)) >= len_eff;
	end

	always_comb begin
		item.is_data   = is_data;
		item.first_row = first_eff;
		item.has_left  = has_left;
		item.last      = last;
		item.filt      = filt_q;
		item.x         = x;
		rd_addr        = idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			first_q <= 1'b1;
			filt_q  <= scu_pkg::FLT_NONE;
		end else if (accept) begin
			if (!is_data) begin
				filt_q  <= scu_pkg::filt_decode(x);
				pos_q   <= PW'(1);
				first_q <= first_eff;
			end else if (last) begin
				pos_q   <= '0;
				first_q <= 1'b0;
			end else begin
				pos_q   <= PW'(idx) + PW'(2);
				first_q <= first_eff;
			end
		end
	end

endmodule

// ===== rtl/scu_recon.sv =====
// scu_recon: stage-1 register, neighbor history and predictor, and the
// output register. Depends on scu_pkg.

module scu_recon #(
	parameter int MAX_PIXEL_BYTES = scu_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  scu_pkg::scu_item_t item_in,
	input  logic [7:0]         up_byte_s1,
	input  logic [3:0]         bpp_eff,
	output logic               in_ready,
	output logic               wr_en,
	output logic [7:0]         wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last
);

	localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	scu_pkg::scu_item_t item_s1;
	logic               valid_s1;
	logic [7:0]         left_q [MAX_PIXEL_BYTES];
	logic [7:0]         upl_q  [MAX_PIXEL_BYTES];
	logic               out_v_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic          adv;
	logic [3:0]    sel_w;
	logic [HW-1:0] sel;
	logic [7:0]    a, b, c, pred, r;
	logic [8:0]    avg_sum;
	logic [9:0]    pa, pb, pc, sab, scc;

	assign adv      = valid_s1 & (~item_s1.is_data | ~out_v_q | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_comb begin
		sel_w = bpp_eff - 4'd1;
		sel   = sel_w[HW-1:0];
		a     = item_s1.has_left ? left_q[sel] : 8'd0;
		b     = item_s1.first_row ? 8'd0 : up_byte_s1;
		c     = (item_s1.has_left && !item_s1.first_row) ? upl_q[sel] : 8'd0;

		avg_sum = {1'b0, a} + {1'b0, b};
		pa      = (b > c) ? 10'(b - c) : 10'(c - b);
		pb      = (a > c) ? 10'(a - c) : 10'(c - a);
		sab     = 10'(a) + 10'(b);
		scc     = {1'b0, c, 1'b0};
		pc      = (sab > scc) ? (sab - scc) : (scc - sab);

		case (item_s1.filt)
			scu_pkg::FLT_SUB:   pred = a;
			scu_pkg::FLT_UP:    pred = b;
			scu_pkg::FLT_AVG:   pred = avg_sum[8:1];
			scu_pkg::FLT_PAETH: begin
				if (pa <= pb && pa <= pc) begin
					pred = a;
				end else if (pb <= pc) begin
					pred = b;
				end else begin
					pred = c;
				end
			end
			default: pred = 8'd0;
		endcase
		r = item_s1.x + pred;
	end

	assign wr_en   = adv & item_s1.is_data;
	assign wr_data = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// filter beat clears both histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= 8'd0;
				upl_q[i]  <= 8'd0;
			end
		end else if (adv) begin
			if (!item_s1.is_data) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= 8'd0;
					upl_q[i]  <= 8'd0;
				end
			end else begin
				left_q[0] <= r;
				upl_q[0]  <= b;
				for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= left_q[i-1];
					upl_q[i]  <= upl_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && item_s1.is_data) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.is_data) begin
			out_byte_q <= r;
			out_last_q <= item_s1.last;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/scanline_unfilter_core.sv =====
// scanline_unfilter_core: PNG scanline unfilter, config registers and stream
// ports. Depends on scu_pkg, scu_ctrl, scu_line_mem, scu_recon.
// Data beats pass stage 1 and the output register; throughput 1 byte/cycle
// unless the output stalls, set by the single line-store read per byte
// issued at input acceptance. Filter-type beats give no result. Reset clears
// position, row state, neighbor history and registers, not the line store.

module scanline_unfilter_core #(
	parameter int MAX_ROW_BYTES   = scu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = scu_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] start_of_image
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_byte
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_ROW_BYTES);

	logic [12:0]        row_bytes_q;
	logic [3:0]         bpp_q;
	logic               accept;
	scu_pkg::scu_item_t item;
	logic [AW-1:0]      rd_addr;
	logic [3:0]         bpp_eff;
	logic [7:0]         up_byte_s1;
	logic               wr_en;
	logic [7:0]         wr_data;

	assign pready = 1'b1;
	assign accept = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= scu_pkg::ROW_BYTES_RST;
			bpp_q       <= scu_pkg::BPP_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				scu_pkg::REG_ROW_BYTES: row_bytes_q <= pwdata[12:0];
				scu_pkg::REG_BPP:       bpp_q       <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			scu_pkg::REG_ROW_BYTES: prdata = {19'd0, row_bytes_q};
			scu_pkg::REG_BPP:       prdata = {28'd0, bpp_q};
			default:                prdata = 32'd0;
		endcase
	end

	scu_ctrl #(
		.MAX_ROW_BYTES   (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
		.AW              (AW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.x               (s_tdata),
		.soi             (s_tuser),
		.row_bytes       (row_bytes_q),
		.bytes_per_pixel (bpp_q),
		.item            (item),
		.rd_addr         (rd_addr),
		.bpp_eff         (bpp_eff)
	);

	scu_line_mem #(
		.DEPTH (MAX_ROW_BYTES),
		.AW    (AW)
	) u_mem (
		.clk        (clk),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.rd_data_s1 (up_byte_s1)
	);

	scu_recon #(
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
	) u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item_in    (item),
		.up_byte_s1 (up_byte_s1),
		.bpp_eff    (bpp_eff),
		.in_ready   (s_tready),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

// ===== rtl/scu_checker.sv =====
// scu_checker: port-level assertions for scanline_unfilter_core, attached
// by bind. Depends on scanline_unfilter_core's port list.

module scu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// input backpressure only comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a new result follows an accepted input beat held in stage 1
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result beat without matching input beat");

	// row length register reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[2] ##1
		psel && !pwrite && !paddr[2] |-> prdata[12:0] == $past(pwdata[12:0]))
		else $error("row_bytes readback mismatch");

endmodule

bind scanline_unfilter_core scu_checker u_scu_checker (.*);

// ===== bench/scanline_unfilter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scanline_unfilter_core: PNG row unfiltering, random flow control.
// Depends on scu_pkg and the core RTL. An in-bench row rebuilder predicts every pixel beat.

class row_rebuilder_t;
	typedef struct {
		logic [7:0] pix;
		logic       eor;
	} pixel_t;

	byte unsigned prev_row [scu_pkg::MAX_ROW_BYTES_DEF];
	byte unsigned left_hist [scu_pkg::MAX_PIXEL_BYTES_DEF];
	byte unsigned upper_hist [scu_pkg::MAX_PIXEL_BYTES_DEF];
	int           pos;
	logic [7:0]   flt;
	bit           top_row;
	logic [12:0]  row_bytes_reg;
	logic [3:0]   bpp_reg;
	pixel_t       pixels_due [$];
	int           errs;

	function new();
		prev_row = '{default: 0};
		left_hist = '{default: 0};
		upper_hist = '{default: 0};
		pos = 0;
		flt = '0;
		top_row = 1'b1;
		row_bytes_reg = scu_pkg::ROW_BYTES_RST;
		bpp_reg = scu_pkg::BPP_RST;
		errs = 0;
	endfunction

	function int row_len();
		if (row_bytes_reg == 0) return 1;
		if (row_bytes_reg > scu_pkg::MAX_ROW_BYTES_DEF) return scu_pkg::MAX_ROW_BYTES_DEF;
		return int'(row_bytes_reg);
	endfunction

	function int pixel_span();
		if (bpp_reg == 0) return 1;
		if (bpp_reg > scu_pkg::MAX_PIXEL_BYTES_DEF) return scu_pkg::MAX_PIXEL_BYTES_DEF;
		return int'(bpp_reg);
	endfunction

	function int paeth_pick(int a, int b, int c);
		int pa, pb, pc;
		pa = (b > c) ? b - c : c - b;
		pb = (a > c) ? a - c : c - a;
		pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	function void note_byte(logic [7:0] x, logic soi);
		int idx, span, a, b, c, p;
		logic [7:0] r;
		pixel_t e;
		span = pixel_span();
		if (soi) begin
			top_row = 1'b1;
			pos = 0;
		end
		if (pos == 0) begin
			flt = x;
			pos = 1;
			left_hist = '{default: 0};
			upper_hist = '{default: 0};
			return;
		end
		idx = pos - 1;
		if (idx >= scu_pkg::MAX_ROW_BYTES_DEF) idx = scu_pkg::MAX_ROW_BYTES_DEF - 1;
		a = (idx >= span) ? left_hist[span - 1] : 0;
		b = top_row ? 0 : prev_row[idx];
		c = (idx >= span && !top_row) ? upper_hist[span - 1] : 0;
		p = 0;
		if (flt <= 8'(scu_pkg::FLT_PAETH)) begin
			case (flt[2:0])
				scu_pkg::FLT_SUB:   p = a;
				scu_pkg::FLT_UP:    p = b;
				scu_pkg::FLT_AVG:   p = (a + b) >> 1;
				scu_pkg::FLT_PAETH: p = paeth_pick(a, b, c);
				default:            p = 0;
			endcase
		end
		r = 8'(x + p);
		prev_row[idx] = r;
		for (int i = scu_pkg::MAX_PIXEL_BYTES_DEF - 1; i > 0; i--) begin
			left_hist[i] = left_hist[i - 1];
			upper_hist[i] = upper_hist[i - 1];
		end
		left_hist[0] = r;
		upper_hist[0] = 8'(b);
		e.pix = r;
		e.eor = (idx + 1 >= row_len());
		if (e.eor) begin
			pos = 0;
			top_row = 1'b0;
		end else begin
			pos = idx + 2;
		end
		pixels_due.insert(pixels_due.size(), e);
	endfunction

	function void check_pixel(logic [7:0] pix, logic eor);
		pixel_t e;
		if (pixels_due.size() == 0) begin
			errs++;
			if (errs <= 10) $display("unexpected pixel beat: %02h last %0b", pix, eor);
			return;
		end
		e = pixels_due.pop_front();
		if (pix !== e.pix || eor !== e.eor) begin
			errs++;
			if (errs <= 10)
				$display("pixel mismatch: expected %02h last %0b, got %02h last %0b",
					e.pix, e.eor, pix, eor);
		end
	endfunction
endclass

module scanline_unfilter_core_tb;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] start_of_image
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] pixel_byte
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	row_rebuilder_t sb = new();
	int send_idle;
	int recv_idle;
	int hold_left;
	int bytes_sent;
	int idle_streak;
	int rb_sel [10]  = '{0, 1, 5, 16, 2, 7, 13, 24, 3, 11};
	int bpp_sel [10] = '{0, 1, 15, 8, 2, 3, 4, 6, 7, 5};

	scanline_unfilter_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random backpressure, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_streak = 0;
		else idle_streak++;
		if (idle_streak >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic soi);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= soi;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(d, soi);
		bytes_sent++;
	endtask

	task automatic flush_pixels();
		s_tvalid <= 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == scu_pkg::REG_ROW_BYTES) sb.row_bytes_reg = val[12:0];
		else sb.bpp_reg = val[3:0];
	endtask

	// upper bits are don't-care in both registers
	task automatic set_geometry(input int unsigned rb, input int unsigned bpp);
		flush_pixels();
		write_reg(scu_pkg::REG_ROW_BYTES, ($urandom & 32'hFFFF_E000) | rb);
		write_reg(scu_pkg::REG_BPP, ($urandom & 32'hFFFF_FFF0) | bpp);
	endtask

	// one image; a broken-off row is abandoned by the next image's start flag
	task automatic send_image(input int rows, input bit may_break);
		int len;
		logic [7:0] code;
		len = sb.row_len();
		for (int r = 0; r < rows; r++) begin
			code = ($urandom_range(0, 9) == 0)
				? 8'($urandom_range(int'(scu_pkg::FLT_PAETH) + 1, 255))
				: 8'($urandom_range(int'(scu_pkg::FLT_NONE), int'(scu_pkg::FLT_PAETH)));
			push_byte(code, r == 0);
			for (int k = 0; k < len; k++) begin
				if (may_break && $urandom_range(0, 99) == 0) return;
				push_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		int target;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_idle = 32;
		recv_idle = 81;
		hold_left = 0;
		bytes_sent = 0;
		idle_streak = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every filter type, byte extremes, unknown code
		set_geometry(3, 2);
		push_byte(8'(scu_pkg::FLT_NONE), 1'b1);
		push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'(scu_pkg::FLT_SUB), 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h7F, 1'b0);
		push_byte(8'(scu_pkg::FLT_UP), 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'(scu_pkg::FLT_AVG), 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'(scu_pkg::FLT_PAETH), 1'b0);
		push_byte(8'h7F, 1'b0); push_byte(8'h80, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b0);
		// geometry change mid-row: next byte is past the new length and ends the row
		push_byte(8'(scu_pkg::FLT_PAETH), 1'b0);
		push_byte(8'hA5, 1'b0);
		set_geometry(1, 1);
		push_byte(8'h5A, 1'b0);
		push_byte(8'(scu_pkg::FLT_UP), 1'b0);
		push_byte(8'h33, 1'b0);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 4) begin
				send_idle = 81;
				recv_idle = 32;
			end
			if (ph == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_geometry(rb_sel[ph], bpp_sel[ph]);
			if (ph == 3 || ph == 7) hold_left = 300;
			target = bytes_sent + 30;
			while (bytes_sent < target) begin
				send_image($urandom_range(1, 4), 1'b1);
				if (ph == 2) flush_pixels();
			end
		end

		// clamped length and pixel size: start of a first row at full width
		set_geometry(8191, 15);
		push_byte(8'(scu_pkg::FLT_PAETH), 1'b1);
		for (int k = 0; k < 24; k++) push_byte(8'($urandom), 1'b0);

		flush_pixels();
		repeat (10) @(posedge clk);
		if (sb.errs == 0 && sb.pixels_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/scu_pkg.sv
rtl/scu_line_mem.sv
rtl/scu_ctrl.sv
rtl/scu_recon.sv
rtl/scanline_unfilter_core.sv
rtl/scu_checker.sv
bench/scanline_unfilter_core_tb.sv
